// ===== rtl/core/pdd_pkg.sv =====
// pdd_pkg: constants, status codes and field layout of the position delta decoder
// used by position_delta_decoder; no dependencies
package pdd_pkg;

    // report layout
    localparam int PREFIX_BYTES = 6;
    localparam int PREFIX_W     = 8 * PREFIX_BYTES;
    localparam int HEADER_LEN   = PREFIX_BYTES + 14;
    localparam int RECORD_LEN   = 6;
    localparam int HDR_POS_W    = $clog2(HEADER_LEN + 1);
    localparam int REC_BYTE_W   = $clog2(RECORD_LEN);
    localparam int DELTA_W      = 8 * (RECORD_LEN - 1);

    // first header position that holds the base time
    localparam int TIME_POS     = PREFIX_BYTES + 1;

    // stream widths
    localparam int S_TDATA_W    = 24;
    localparam int M_PAYLOAD_W  = 32 * 3 + PREFIX_W + 8 + 9;
    localparam int M_TDATA_W    = ((M_PAYLOAD_W + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_REPORT_VERSION = 1'b0,
        CFG_SAMPLE_LIMIT   = 1'b1
    } cfg_index_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_SAMPLE      = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_VERSION = 3'd2,
        ST_NO_ROOM     = 3'd3,
        ST_TRUNCATED   = 3'd4
    } status_t;

    localparam logic [7:0] VERSION_RESET = 8'd1;
    localparam logic [8:0] LIMIT_RESET   = 9'd256;

endpackage

// ===== rtl/core/position_delta_decoder.sv =====
// position_delta_decoder: byte-serial decoder for delta-coded position reports
// depends on pdd_pkg
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------------
//   s_        | in        | one report byte, first-byte flag, packet length
//   m_        | out       | status, reconstructed sample, key prefix, index, count
//   cfg_      | in        | write-only registers: report version, sample limit
//
// one byte per cycle: each byte is decoded by a single layer of shift/add logic
// between the input handshake and the result register, so bytes enter back to back.
// a result appears on m_ in the cycle after the byte that causes it is taken.
// s_tready drops only while a result waits in the output register and m_tready is low.
// aresetn is synchronous; after reset the decoder ignores bytes until a first byte.
module position_delta_decoder
    import pdd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // data_byte[7:0], packet_length[23:8]
    input  logic [0:0]             s_tuser,   // first_byte[0]

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // sample_time[31:0], latitude[63:32],
                                              // longitude[95:64], key_prefix[143:96],
                                              // sample_index[151:144],
                                              // samples_returned[160:152], zeros above
    output logic [2:0]             m_tuser,   // status[2:0]
    output logic                   m_tlast,   // is_last

    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_addr,
    input  logic [8:0]             cfg_wdata
);

    localparam logic [HDR_POS_W-1:0] CNT_BYTE_POS = HDR_POS_W'(HEADER_LEN - 1);
    localparam logic [HDR_POS_W-1:0] PFX_LAST     = HDR_POS_W'(PREFIX_BYTES);
    localparam logic [16:0]          HDR_LEN17    = 17'(HEADER_LEN);

    // configuration
    logic [7:0]               version_reg;
    logic [8:0]               limit_reg;

    // decoder state
    logic [HDR_POS_W-1:0]     hdr_pos_reg,   hdr_pos_next;
    logic [REC_BYTE_W-1:0]    rec_byte_reg,  rec_byte_next;
    logic [7:0]               rec_left_reg,  rec_left_next;
    logic [31:0]              time_reg,      time_next;
    logic [31:0]              lat_reg,       lat_next;
    logic [31:0]              lon_reg,       lon_next;
    logic [PREFIX_W-1:0]      prefix_reg,    prefix_next;
    logic [DELTA_W-1:0]       delta_reg,     delta_next;
    logic [15:0]              exp_len_reg,   exp_len_next;
    logic [8:0]               emitted_reg,   emitted_next;
    logic [8:0]               total_reg,     total_next;
    logic                     ignoring_reg,  ignoring_next;

    // output register
    logic                     out_vld_reg,   out_vld_next;
    logic [M_TDATA_W-1:0]     out_data_reg,  out_data_next;
    status_t                  out_stat_reg,  out_stat_next;
    logic                     out_last_reg,  out_last_next;

    logic                     in_fire;
    logic [7:0]               in_byte;
    logic [15:0]              in_len;
    logic                     in_first;

    logic                     res_vld;
    status_t                  res_stat;
    logic [7:0]               res_idx;
    logic                     res_last;
    logic [16:0]              need_len;
    logic [8:0]               count_lim;
    logic [3:0]               word_off;
    logic [8:0]               emitted_inc;

    assign s_tready = !out_vld_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign in_byte  = s_tdata[7:0];
    assign in_len   = s_tdata[23:8];
    assign in_first = s_tuser[0];

    // count byte check: header plus six bytes per record
    assign need_len    = HDR_LEN17 + {6'd0, in_byte, 3'd0} - {8'd0, in_byte, 1'b0};
    assign word_off    = 4'(hdr_pos_reg - HDR_POS_W'(TIME_POS));
    assign emitted_inc = emitted_reg + 9'd1;

    always_comb begin
        hdr_pos_next  = hdr_pos_reg;
        rec_byte_next = rec_byte_reg;
        rec_left_next = rec_left_reg;
        time_next     = time_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        prefix_next   = prefix_reg;
        delta_next    = delta_reg;
        exp_len_next  = exp_len_reg;
        emitted_next  = emitted_reg;
        total_next    = total_reg;
        ignoring_next = ignoring_reg;
        res_vld       = 1'b0;
        res_stat      = ST_SAMPLE;
        res_idx       = 8'd0;
        res_last      = 1'b0;
        count_lim     = {1'b0, in_byte} + 9'd1;

        if (in_fire) begin
            if (in_first) begin
                priority if (in_len < 16'(HEADER_LEN)) begin
                    res_vld       = 1'b1;
                    res_stat      = ST_TOO_SHORT;
                    res_last      = 1'b1;
                    ignoring_next = 1'b1;
                end else if (in_byte != version_reg) begin
                    res_vld       = 1'b1;
                    res_stat      = ST_BAD_VERSION;
                    res_last      = 1'b1;
                    ignoring_next = 1'b1;
                end else if (limit_reg == 9'd0) begin
                    res_vld       = 1'b1;
                    res_stat      = ST_NO_ROOM;
                    res_last      = 1'b1;
                    ignoring_next = 1'b1;
                end else begin
                    ignoring_next = 1'b0;
                    hdr_pos_next  = HDR_POS_W'(1);
                    rec_byte_next = '0;
                    rec_left_next = 8'd0;
                    time_next     = 32'd0;
                    lat_next      = 32'd0;
                    lon_next      = 32'd0;
                    prefix_next   = '0;
                    delta_next    = '0;
                    exp_len_next  = in_len;
                    emitted_next  = 9'd0;
                    total_next    = limit_reg;
                end
            end else if (!ignoring_reg) begin
                priority if (hdr_pos_reg < CNT_BYTE_POS) begin
                    // header bytes land in their lane, little-endian
                    if (hdr_pos_reg <= PFX_LAST) begin
                        for (int i = 0; i < PREFIX_BYTES; i++) begin
                            if (hdr_pos_reg == HDR_POS_W'(i + 1)) begin
                                prefix_next[8*i +: 8] = in_byte;
                            end
                        end
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            if (word_off[1:0] == 2'(i)) begin
                                priority if (word_off[3:2] == 2'd0) begin
                                    time_next[8*i +: 8] = in_byte;
                                end else if (word_off[3:2] == 2'd1) begin
                                    lat_next[8*i +: 8] = in_byte;
                                end else begin
                                    lon_next[8*i +: 8] = in_byte;
                                end
                            end
                        end
                    end
                    hdr_pos_next = hdr_pos_reg + HDR_POS_W'(1);
                end else if (hdr_pos_reg == CNT_BYTE_POS) begin
                    if ({1'b0, exp_len_reg} < need_len) begin
                        res_vld       = 1'b1;
                        res_stat      = ST_TRUNCATED;
                        res_last      = 1'b1;
                        ignoring_next = 1'b1;
                    end else begin
                        if (total_reg < count_lim) begin
                            count_lim = total_reg;
                        end
                        total_next    = count_lim;
                        hdr_pos_next  = HDR_POS_W'(HEADER_LEN);
                        rec_left_next = in_byte;
                        rec_byte_next = '0;
                        delta_next    = '0;
                        emitted_next  = 9'd1;
                        if (in_byte == 8'd0) begin
                            ignoring_next = 1'b1;
                        end
                        res_vld  = 1'b1;
                        res_last = (count_lim == 9'd1);
                    end
                end else begin
                    if (rec_byte_reg < REC_BYTE_W'(RECORD_LEN - 1)) begin
                        for (int i = 0; i < RECORD_LEN - 1; i++) begin
                            if (rec_byte_reg == REC_BYTE_W'(i)) begin
                                delta_next[8*i +: 8] = in_byte;
                            end
                        end
                        rec_byte_next = rec_byte_reg + REC_BYTE_W'(1);
                    end else begin
                        time_next = time_reg + {16'd0, delta_reg[15:0]};
                        lat_next  = lat_reg + {{16{delta_reg[31]}}, delta_reg[31:16]};
                        lon_next  = lon_reg + {{16{in_byte[7]}}, in_byte, delta_reg[39:32]};
                        rec_byte_next = '0;
                        delta_next    = '0;
                        rec_left_next = rec_left_reg - 8'd1;
                        if (rec_left_next == 8'd0) begin
                            ignoring_next = 1'b1;
                        end
                        // records past the limit still move the accumulators
                        if (emitted_reg < total_reg) begin
                            res_vld      = 1'b1;
                            res_idx      = emitted_reg[7:0];
                            emitted_next = emitted_inc;
                            res_last     = (emitted_inc == total_reg);
                        end
                    end
                end
            end
        end
    end

    // result register
    always_comb begin
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        out_stat_next = out_stat_reg;
        out_last_next = out_last_reg;
        if (res_vld) begin
            out_vld_next  = 1'b1;
            out_stat_next = res_stat;
            out_last_next = res_last;
            out_data_next = '0;
            if (res_stat == ST_SAMPLE) begin
                out_data_next[M_PAYLOAD_W-1:0] =
                    {total_next, res_idx, prefix_next, lon_next, lat_next, time_next};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg  <= VERSION_RESET;
            limit_reg    <= LIMIT_RESET;
            hdr_pos_reg  <= '0;
            rec_byte_reg <= '0;
            rec_left_reg <= 8'd0;
            time_reg     <= 32'd0;
            lat_reg      <= 32'd0;
            lon_reg      <= 32'd0;
            prefix_reg   <= '0;
            delta_reg    <= '0;
            exp_len_reg  <= 16'd0;
            emitted_reg  <= 9'd0;
            total_reg    <= 9'd0;
            ignoring_reg <= 1'b1;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_REPORT_VERSION: version_reg <= cfg_wdata[7:0];
                    CFG_SAMPLE_LIMIT:   limit_reg   <= cfg_wdata;
                    default:            ;
                endcase
            end
            hdr_pos_reg  <= hdr_pos_next;
            rec_byte_reg <= rec_byte_next;
            rec_left_reg <= rec_left_next;
            time_reg     <= time_next;
            lat_reg      <= lat_next;
            lon_reg      <= lon_next;
            prefix_reg   <= prefix_next;
            delta_reg    <= delta_next;
            exp_len_reg  <= exp_len_next;
            emitted_reg  <= emitted_next;
            total_reg    <= total_next;
            ignoring_reg <= ignoring_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // never more samples than the report allows
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emitted_reg <= total_reg)
        else $error("emitted count exceeds samples to return");

    // a rejection always closes the report
    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_SAMPLE) |-> m_tlast)
        else $error("rejection without last flag");

    // sample index stays below the announced count
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_SAMPLE) |-> ({1'b0, m_tdata[151:144]} < m_tdata[160:152]))
        else $error("sample index out of range");

    // a byte that produces a result is only taken when the output can hold it
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_tready |=> $stable(out_data_reg))
        else $error("pending result overwritten");
`endif

endmodule

// ===== sim/position_delta_decoder_test.sv =====
// position_delta_decoder_test: self-checking bench for the position delta decoder
// sends position reports byte by byte and compares each result with its own decode
// depends on pdd_pkg and position_delta_decoder
module position_delta_decoder_test;
    import pdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 230;

    typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_EDGES} fill_t;

    typedef struct {
        status_t            status;
        logic [31:0]        stamp;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
        logic [47:0]        prefix;
        logic [7:0]         index;
        logic [8:0]         count;
        logic               is_last;
    } sample_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [0:0]           cfg_addr = '0;
    logic [8:0]           cfg_wdata = '0;

    // decoder copy kept by the bench
    logic [7:0]  cur_version = VERSION_RESET;
    logic [8:0]  cur_limit = LIMIT_RESET;
    int          hdr_pos = 0;
    int          rec_byte = 0;
    logic [7:0]  recs_left = '0;
    logic [31:0] run_time = '0;
    logic [31:0] run_lat = '0;
    logic [31:0] run_lon = '0;
    logic [47:0] key_bytes = '0;
    logic [39:0] delta = '0;
    logic [15:0] exp_len = '0;
    int          emitted = 0;
    int          total = 0;
    bit          skipping = 1'b1;

    sample_t samples_due[$];
    int      error_count = 0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;

    position_delta_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("position_delta_decoder_test NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < 50)
            $display("mismatch %s: got %0h expected %0h at cycle %0d",
                     field, got, want, cycle_count);
        error_count++;
    endtask

    task automatic push_sample(input int idx, input bit is_last);
        sample_t s;
        s.status  = ST_SAMPLE;
        s.stamp   = run_time;
        s.lat     = run_lat;
        s.lon     = run_lon;
        s.prefix  = key_bytes;
        s.index   = idx[7:0];
        s.count   = total[8:0];
        s.is_last = is_last;
        samples_due.push_back(s);
    endtask

    task automatic push_reject(input status_t code);
        sample_t s;
        skipping  = 1'b1;
        s.status  = code;
        s.stamp   = '0;
        s.lat     = '0;
        s.lon     = '0;
        s.prefix  = '0;
        s.index   = '0;
        s.count   = '0;
        s.is_last = 1'b1;
        samples_due.push_back(s);
    endtask

    // advances the bench's decoder by one accepted byte
    task automatic decode_byte(input logic [7:0] b, input logic is_first,
                               input logic [15:0] len);
        int off;
        if (is_first) begin
            if (len < HEADER_LEN) push_reject(ST_TOO_SHORT);
            else if (b != cur_version) push_reject(ST_BAD_VERSION);
            else if (cur_limit == 0) push_reject(ST_NO_ROOM);
            else begin
                skipping  = 1'b0;
                hdr_pos   = 1;
                rec_byte  = 0;
                recs_left = '0;
                run_time  = '0;
                run_lat   = '0;
                run_lon   = '0;
                key_bytes = '0;
                delta     = '0;
                exp_len   = len;
                emitted   = 0;
                total     = cur_limit;
            end
        end else if (!skipping) begin
            if (hdr_pos < HEADER_LEN - 1) begin
                if (hdr_pos <= PREFIX_BYTES) begin
                    key_bytes[8*(hdr_pos-1) +: 8] = b;
                end else begin
                    off = hdr_pos - 1 - PREFIX_BYTES;
                    if (off < 4) run_time[8*(off%4) +: 8] = b;
                    else if (off < 8) run_lat[8*(off%4) +: 8] = b;
                    else run_lon[8*(off%4) +: 8] = b;
                end
                hdr_pos++;
            end else if (hdr_pos == HEADER_LEN - 1) begin
                // count byte: the whole record area must fit in the stated length
                if (int'(exp_len) < HEADER_LEN + RECORD_LEN * int'(b)) begin
                    push_reject(ST_TRUNCATED);
                end else begin
                    if (int'(b) + 1 < total) total = int'(b) + 1;
                    hdr_pos   = HEADER_LEN;
                    recs_left = b;
                    rec_byte  = 0;
                    delta     = '0;
                    emitted   = 1;
                    if (b == 0) skipping = 1'b1;
                    push_sample(0, total == 1);
                end
            end else if (rec_byte < RECORD_LEN - 1) begin
                delta[8*rec_byte +: 8] = b;
                rec_byte++;
            end else begin
                run_time += {16'h0, delta[15:0]};
                run_lat  += {{16{delta[31]}}, delta[31:16]};
                run_lon  += {{16{b[7]}}, b, delta[39:32]};
                rec_byte  = 0;
                delta     = '0;
                recs_left = recs_left - 8'd1;
                if (recs_left == 0) skipping = 1'b1;
                // records past the limit still move the accumulators
                if (emitted < total) begin
                    emitted++;
                    push_sample(emitted - 1, emitted == total);
                end
            end
        end
    endtask

    always @(posedge aclk) begin : check_results
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (samples_due.size() == 0) begin
                report_mismatch("unexpected item, status", m_tuser, '0);
            end else begin
                want = samples_due.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[31:0] !== want.stamp)
                    report_mismatch("sample_time", m_tdata[31:0], want.stamp);
                if (m_tdata[63:32] !== want.lat)
                    report_mismatch("latitude", m_tdata[63:32], want.lat);
                if (m_tdata[95:64] !== want.lon)
                    report_mismatch("longitude", m_tdata[95:64], want.lon);
                if (m_tdata[143:96] !== want.prefix)
                    report_mismatch("key_prefix", m_tdata[143:96], want.prefix);
                if (m_tdata[151:144] !== want.index)
                    report_mismatch("sample_index", m_tdata[151:144], want.index);
                if (m_tdata[160:152] !== want.count)
                    report_mismatch("samples_returned", m_tdata[160:152], want.count);
                if (m_tlast !== want.is_last)
                    report_mismatch("is_last", m_tlast, want.is_last);
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic is_first,
                             input logic [15:0] len);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, data};
        s_tuser  <= is_first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(data, is_first, len);
        bytes_sent++;
    endtask

    // stop sending and let every pending result drain out
    task automatic wait_for_samples();
        s_tvalid <= 1'b0;
        while (samples_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [8:0] value);
        wait_for_samples();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_REPORT_VERSION) cur_version = value[7:0];
        else cur_limit = value;
    endtask

    function automatic logic [7:0] pick_byte(input fill_t fill);
        logic [1:0] r;
        r = 2'($urandom);
        case (fill)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            FILL_EDGES: return {r[1], {7{r[0]}}};
            default:    return 8'($urandom);
        endcase
    endfunction

    // one report: version byte with its length, header, count, records, extra bytes;
    // total_bytes may cut it short or run past its end
    task automatic send_report(input logic [7:0] version, input int count, input int len,
                               input int total_bytes, input fill_t fill);
        int n;
        send_byte(version, 1'b1, len[15:0]);
        for (n = 1; n < total_bytes; n++) begin
            if (n == HEADER_LEN - 1)
                send_byte(count[7:0], 1'b0, 16'($urandom));
            else
                send_byte(pick_byte(fill), 1'b0, 16'($urandom));
        end
    endtask

    function automatic int report_len(input int count);
        return HEADER_LEN + RECORD_LEN * count;
    endfunction

    task automatic test_rejections();
        send_byte(8'h01, 1'b0, 16'h0014);
        send_byte(8'hA5, 1'b0, 16'hFFFF);
        send_report(8'h01, 0, HEADER_LEN - 1, 3, FILL_RANDOM);
        send_report(8'h01, 0, 0, 1, FILL_RANDOM);
        send_report(8'h00, 0, 5, 2, FILL_RANDOM);
        send_report(8'hFE, 0, HEADER_LEN, HEADER_LEN, FILL_RANDOM);
        send_report(8'h01, 3, report_len(3) - 1, report_len(3), FILL_RANDOM);
        send_report(8'h01, 255, 16'hFFFE, 24, FILL_RANDOM);
        wait_for_samples();
    endtask

    task automatic test_extremes();
        send_report(8'h01, 0, HEADER_LEN, HEADER_LEN, FILL_ONES);
        send_report(8'h01, 2, report_len(2), report_len(2), FILL_ONES);
        send_report(8'h01, 2, report_len(2), report_len(2), FILL_ZEROS);
        send_report(8'h01, 3, report_len(3), report_len(3), FILL_EDGES);
        // largest count: one byte short is truncated, the full length stops after 200 bytes
        send_report(8'h01, 255, report_len(255) - 1, HEADER_LEN, FILL_EDGES);
        send_report(8'h01, 255, report_len(255), 200, FILL_EDGES);
        wait_for_samples();
    endtask

    task automatic test_limits();
        write_register(CFG_SAMPLE_LIMIT, 9'd0);
        send_report(8'h01, 1, report_len(1), report_len(1), FILL_RANDOM);
        send_report(8'h07, 0, HEADER_LEN, 1, FILL_RANDOM);
        send_report(8'h01, 0, 3, 1, FILL_RANDOM);
        write_register(CFG_SAMPLE_LIMIT, 9'd1);
        send_report(8'h01, 4, report_len(4), report_len(4), FILL_RANDOM);
        send_report(8'h01, 0, report_len(0), report_len(0), FILL_RANDOM);
        write_register(CFG_SAMPLE_LIMIT, 9'd2);
        send_report(8'h01, 1, report_len(1), report_len(1), FILL_RANDOM);
        send_report(8'h01, 5, report_len(5), report_len(5), FILL_RANDOM);
        write_register(CFG_SAMPLE_LIMIT, 9'd511);
        send_report(8'h01, 5, report_len(5), report_len(5), FILL_EDGES);
        write_register(CFG_SAMPLE_LIMIT, LIMIT_RESET);
        write_register(CFG_REPORT_VERSION, 9'd0);
        send_report(8'h00, 1, report_len(1), report_len(1), FILL_RANDOM);
        send_report(8'h01, 1, report_len(1), report_len(1), FILL_RANDOM);
        write_register(CFG_REPORT_VERSION, 9'd255);
        send_report(8'hFF, 2, report_len(2), report_len(2), FILL_RANDOM);
        write_register(CFG_REPORT_VERSION, 9'(VERSION_RESET));
    endtask

    task automatic test_abandon();
        // a new first byte drops the report in flight with no further result for it
        send_report(8'h01, 4, report_len(4), 10, FILL_RANDOM);
        send_report(8'h01, 4, report_len(4), 35, FILL_RANDOM);
        send_report(8'h01, 2, report_len(2), HEADER_LEN - 1, FILL_RANDOM);
        send_report(8'h01, 2, report_len(2), report_len(2), FILL_RANDOM);
        wait_for_samples();
    endtask

    task automatic test_trailing();
        send_report(8'h01, 2, report_len(2) + 5, report_len(2) + 5, FILL_RANDOM);
        send_report(8'h01, 1, report_len(1), report_len(1) + 4, FILL_RANDOM);
        send_report(8'h01, 0, report_len(0), report_len(0) + 7, FILL_RANDOM);
        wait_for_samples();
    endtask

    task automatic test_random_traffic(input int idle, input int stall);
        int start;
        int kind;
        int count;
        int len;
        int natural_len;
        bit paused;
        logic [7:0] version;
        fill_t fill;
        start     = bytes_sent;
        paused    = 1'b0;
        idle_pct  = idle;
        stall_pct = stall;
        while (bytes_sent - start < PHASE_BYTES) begin
            kind        = $urandom_range(99);
            count       = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(8);
            natural_len = report_len(count);
            len         = natural_len;
            version     = cur_version;
            fill        = ($urandom_range(4) == 0) ? FILL_EDGES : FILL_RANDOM;
            if (kind < 70) begin
                if ($urandom_range(15) == 0)
                    len = natural_len + $urandom_range(65535 - natural_len);
                else if ($urandom_range(3) == 0)
                    len = natural_len + $urandom_range(20);
                send_report(version, count, len, natural_len + $urandom_range(2), fill);
            end else if (kind < 80) begin
                if (count == 0) count = 1;
                natural_len = report_len(count);
                len = natural_len - $urandom_range(1, RECORD_LEN);
                if (len < HEADER_LEN) len = HEADER_LEN;
                send_report(version, count, len, natural_len, fill);
            end else if (kind < 88) begin
                send_report(version, count, len, $urandom_range(1, natural_len - 1), fill);
            end else if (kind < 94) begin
                version = cur_version ^ 8'($urandom_range(1, 255));
                send_report(version, count, len, HEADER_LEN, fill);
            end else begin
                send_byte(8'($urandom), 1'b1, 16'($urandom));
            end
            if (!paused && bytes_sent - start > PHASE_BYTES / 2) begin
                paused = 1'b1;
                wait_for_samples();
            end
        end
        wait_for_samples();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_rejections();
        test_extremes();
        test_limits();
        test_abandon();
        test_trailing();
        write_register(CFG_REPORT_VERSION, 9'($urandom_range(255)));
        test_random_traffic(0, 0);
        write_register(CFG_REPORT_VERSION, 9'($urandom_range(255)));
        write_register(CFG_SAMPLE_LIMIT, 9'($urandom_range(1, 8)));
        test_random_traffic(63, 0);
        write_register(CFG_SAMPLE_LIMIT, 9'($urandom_range(1, 511)));
        test_random_traffic(0, 63);
        write_register(CFG_REPORT_VERSION, 9'($urandom_range(255)));
        write_register(CFG_SAMPLE_LIMIT, LIMIT_RESET);
        test_random_traffic(15, 15);
        idle_pct  = 0;
        stall_pct = 0;
        wait_for_samples();
        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("position_delta_decoder_test OK");
        else
            $display("position_delta_decoder_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pdd_pkg.sv
rtl/core/position_delta_decoder.sv
sim/position_delta_decoder_test.sv
